@@ hdl/mqd_pkg.sv @@
package mqd_pkg;

  localparam int MAX_LENGTH_BYTES = 4;

  localparam logic [3:0] TYPE_CONNACK = 4'd2;
  localparam logic [3:0] TYPE_PUBLISH = 4'd3;
  localparam logic [3:0] TYPE_SUBACK  = 4'd9;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    K_TOPIC     = 3'd0,
    K_PAYLOAD   = 3'd1,
    K_MSG_END   = 3'd2,
    K_PUBACK    = 3'd3,
    K_CONN_OK   = 3'd4,
    K_CONN_REJ  = 3'd5,
    K_SUBACK    = 3'd6,
    K_LEN_ERR   = 3'd7
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [15:0] packet_id;
    logic        last;
  } result_t;

  // Up to three results from one received word, packed from entry 0 upwards.
  typedef struct packed {
    logic [1:0]        n;
    result_t [2:0]     item;
  } res_set_t;

endpackage

@@ hdl/mqd_in_if.sv @@
interface mqd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ hdl/mqd_out_if.sv @@
interface mqd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  data;
  logic [15:0] packet_id;
  logic        last;

  modport source (output valid, output kind, output data, output packet_id, output last,
                  input ready);
  modport sink   (input valid, input kind, input data, input packet_id, input last,
                  output ready);
endinterface

@@ hdl/mqd_core.sv @@
module mqd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output mqd_pkg::res_set_t res
);
  import mqd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  type_r, type_nxt;
  logic [1:0]  qos_r, qos_nxt;
  logic [1:0]  lbi_r, lbi_nxt;
  logic [27:0] rl_r, rl_nxt;
  logic [27:0] bc_r, bc_nxt;
  logic [15:0] tl_r, tl_nxt;
  logic [15:0] held_r, held_nxt;
  logic        drop_r, drop_nxt;

  logic        a_v, b_v, c_v, end_en;
  kind_t       a_kind, b_kind;
  logic [7:0]  a_data, b_data;
  logic [15:0] b_pid;
  logic [27:0] addend, rl_sum;
  logic [15:0] tl_new;
  logic [17:0] need;
  logic [16:0] lim2, lim4;
  result_t     ra, rb, rc, e0, e1, e2;
  logic [1:0]  n;

  always_comb begin
    phase_nxt = phase_r;
    type_nxt  = type_r;
    qos_nxt   = qos_r;
    lbi_nxt   = lbi_r;
    rl_nxt    = rl_r;
    bc_nxt    = bc_r;
    tl_nxt    = tl_r;
    held_nxt  = held_r;
    drop_nxt  = drop_r;
    a_v       = 1'b0;
    a_kind    = K_TOPIC;
    a_data    = 8'd0;
    b_v       = 1'b0;
    b_kind    = K_MSG_END;
    b_data    = 8'd0;
    b_pid     = 16'd0;
    c_v       = 1'b0;
    end_en    = 1'b0;
    tl_new    = {tl_r[15:8], rx_byte};
    need      = 18'd2 + {2'd0, tl_new} + ((qos_r != 2'd0) ? 18'd2 : 18'd0);
    lim2      = {1'b0, tl_r} + 17'd2;
    lim4      = {1'b0, tl_r} + 17'd4;

    unique case (lbi_r)
      2'd0:    addend = {21'd0, rx_byte[6:0]};
      2'd1:    addend = {14'd0, rx_byte[6:0], 7'd0};
      2'd2:    addend = {7'd0, rx_byte[6:0], 14'd0};
      default: addend = {rx_byte[6:0], 21'd0};
    endcase
    rl_sum = rl_r + addend;

    unique case (phase_r)
      PH_LENGTH: begin
        rl_nxt = rl_sum;
        if (!rx_byte[7]) begin
          bc_nxt   = 28'd0;
          tl_nxt   = 16'd0;
          held_nxt = 16'd0;
          drop_nxt = 1'b0;
          if (rl_sum == 28'd0) begin
            end_en = 1'b1;
          end else begin
            phase_nxt = PH_BODY;
          end
        end else if ({1'b0, lbi_r} + 3'd1 >= 3'(MAX_LENGTH_BYTES)) begin
          a_v       = 1'b1;
          a_kind    = K_LEN_ERR;
          phase_nxt = PH_HEADER;
        end else begin
          lbi_nxt = lbi_r + 2'd1;
        end
      end
      PH_BODY: begin
        bc_nxt = bc_r + 28'd1;
        if (type_r == TYPE_CONNACK) begin
          if (bc_r == 28'd1) begin
            held_nxt = {8'd0, rx_byte};
          end
        end else if (type_r == TYPE_PUBLISH) begin
          if (bc_r == 28'd0) begin
            tl_nxt = {rx_byte, 8'd0};
          end else if (bc_r == 28'd1) begin
            tl_nxt = tl_new;
            if ({10'd0, need} > rl_r) begin
              drop_nxt = 1'b1;
            end
          end else if (!drop_r) begin
            if (bc_r < {11'd0, lim2}) begin
              a_v    = 1'b1;
              a_kind = K_TOPIC;
              a_data = rx_byte;
            end else if (qos_r != 2'd0 && bc_r < {11'd0, lim4}) begin
              held_nxt = {held_r[7:0], rx_byte};
            end else begin
              a_v    = 1'b1;
              a_kind = K_PAYLOAD;
              a_data = rx_byte;
            end
          end
        end
        if ({1'b0, bc_r} + 29'd1 >= {1'b0, rl_r}) begin
          end_en = 1'b1;
        end
      end
      default: begin
        // Any other phase code is treated as waiting for a header word.
        type_nxt  = rx_byte[7:4];
        qos_nxt   = rx_byte[2:1];
        lbi_nxt   = 2'd0;
        rl_nxt    = 28'd0;
        phase_nxt = PH_LENGTH;
      end
    endcase

    if (end_en) begin
      phase_nxt = PH_HEADER;
      if (type_r == TYPE_CONNACK) begin
        if (rl_nxt >= 28'd2) begin
          b_v    = 1'b1;
          b_kind = (held_nxt[7:0] == 8'd0) ? K_CONN_OK : K_CONN_REJ;
          b_data = held_nxt[7:0];
        end
      end else if (type_r == TYPE_SUBACK) begin
        b_v    = 1'b1;
        b_kind = K_SUBACK;
      end else if (type_r == TYPE_PUBLISH) begin
        if (rl_nxt >= 28'd2 && !drop_nxt) begin
          b_v    = 1'b1;
          b_kind = K_MSG_END;
          b_pid  = held_nxt;
          c_v    = (qos_r == 2'd1);
        end
      end
    end
  end

  // Compact the body result, the end result and the puback request.
  always_comb begin
    ra = '{kind: a_kind,   data: a_data, packet_id: 16'd0, last: 1'b0};
    rb = '{kind: b_kind,   data: b_data, packet_id: b_pid, last: 1'b0};
    rc = '{kind: K_PUBACK, data: 8'd0,   packet_id: b_pid, last: 1'b0};
    n  = 2'({1'b0, a_v} + {1'b0, b_v} + {1'b0, c_v});
    e0 = a_v ? ra : rb;
    e1 = a_v ? rb : rc;
    e2 = rc;
    e0.last = (n == 2'd1);
    e1.last = (n == 2'd2);
    e2.last = (n == 2'd3);
    res.n    = n;
    res.item = {e2, e1, e0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      type_r  <= 4'd0;
      qos_r   <= 2'd0;
      lbi_r   <= 2'd0;
      rl_r    <= 28'd0;
      bc_r    <= 28'd0;
      tl_r    <= 16'd0;
      held_r  <= 16'd0;
      drop_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      type_r  <= type_nxt;
      qos_r   <= qos_nxt;
      lbi_r   <= lbi_nxt;
      rl_r    <= rl_nxt;
      bc_r    <= bc_nxt;
      tl_r    <= tl_nxt;
      held_r  <= held_nxt;
      drop_r  <= drop_nxt;
    end
  end

  a_body_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> rl_r != 28'd0)
    else $error("body phase entered with zero remaining length");

  a_len_index: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_LENGTH |-> {1'b0, lbi_r} < 3'(MAX_LENGTH_BYTES))
    else $error("length byte index beyond the varint limit");

endmodule

@@ hdl/mqtt_receive_deframer_top.sv @@
// An accepted word is held in the input register until the result registers have room; the
// parser then works on it and its results are registered before they appear on the port.
// Throughput: one word per cycle while each word gives at most one result and the result side
// is ready; a word that gives more results holds the single result port until its last is taken.
// Reset (rst_n low at a clock edge) empties the input and result registers and returns
// the parser to waiting for a fixed header word.
module mqtt_receive_deframer_top (
  input  logic      clk,
  input  logic      rst_n,
  mqd_in_if.sink    in_bus,
  mqd_out_if.source out_bus
);
  import mqd_pkg::*;

  logic          in_v_r;
  logic [7:0]    byte_r;
  result_t [2:0] res_r;
  logic [1:0]    cnt_r;
  logic          pop, buf_free, proc;
  res_set_t      res;

  assign pop      = (cnt_r != 2'd0) && out_bus.ready;
  assign buf_free = (cnt_r == 2'd0) || (cnt_r == 2'd1 && pop);
  assign proc     = in_v_r && buf_free;

  assign in_bus.ready = !in_v_r || proc;

  mqd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (proc),
    .rx_byte (byte_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_bus.valid && in_bus.ready) begin
      in_v_r <= 1'b1;
    end else if (proc) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      byte_r <= in_bus.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (proc) begin
      cnt_r <= res.n;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // Results leave from entry 0; the rest move down one place on each taken word.
  always_ff @(posedge clk) begin
    if (proc) begin
      res_r <= res.item;
    end else if (pop) begin
      res_r[0] <= res_r[1];
      res_r[1] <= res_r[2];
    end
  end

  assign out_bus.valid     = (cnt_r != 2'd0);
  assign out_bus.kind      = res_r[0].kind;
  assign out_bus.data      = res_r[0].data;
  assign out_bus.packet_id = res_r[0].packet_id;
  assign out_bus.last      = res_r[0].last;

  a_last_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r > 2'd1 |-> !res_r[0].last)
    else $error("last flag set with further results queued");

  a_last_on_single: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd1 |-> res_r[0].last)
    else $error("final queued result lacks the last flag");

  a_puback_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r >= 2'd2 && res_r[0].kind == K_MSG_END) |-> res_r[1].kind == K_PUBACK)
    else $error("message end followed by something other than a puback request");

  a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !buf_free) |=> (in_v_r && $stable(byte_r)))
    else $error("pending word lost while the result queue was busy");

endmodule

@@ dv/mqtt_receive_deframer_top_tb.sv @@
module mqtt_receive_deframer_top_tb;
  import mqd_pkg::*;

  localparam int RANDOM_WORDS = 200;
  localparam int CALM_TAIL    = 40;
  localparam int STALL_LIMIT  = 1000;
  localparam int HOLD_CYCLES  = 80;
  localparam int HOLD_AT      = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mqd_in_if  in_bus();
  mqd_out_if out_bus();

  mqtt_receive_deframer_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [7:0] rx_stream[$];
  result_t    due_results[$];
  int         total_words;
  int         idle_stop;
  int         in_count = 0;
  int         errors = 0;
  int         quiet_cycles = 0;
  logic       in_acc = 1'b0;
  int         in_gap = 0;
  int         out_gap = 0;
  int         hold_cnt = 0;
  logic       hold_done = 1'b0;

  // Parser state as the block should hold it.
  phase_t      ph = PH_HEADER;
  logic [3:0]  pkt_type = '0;
  logic [1:0]  pub_qos = '0;
  logic [1:0]  len_idx = '0;
  logic [27:0] rem_len = '0;
  logic [27:0] body_cnt = '0;
  logic [15:0] topic_len = '0;
  logic [15:0] id_hold = '0;
  logic        dropping = 1'b0;

  task automatic emit(kind_t k, logic [7:0] d, logic [15:0] pid);
    result_t r;
    r.kind      = k;
    r.data      = d;
    r.packet_id = pid;
    r.last      = 1'b0;
    due_results.push_back(r);
  endtask

  task automatic close_packet();
    if (pkt_type == TYPE_CONNACK) begin
      if (rem_len >= 28'd2)
        emit((id_hold[7:0] == 8'd0) ? K_CONN_OK : K_CONN_REJ, id_hold[7:0], 16'd0);
    end else if (pkt_type == TYPE_SUBACK) begin
      emit(K_SUBACK, 8'd0, 16'd0);
    end else if (pkt_type == TYPE_PUBLISH) begin
      if (rem_len >= 28'd2 && !dropping) begin
        emit(K_MSG_END, 8'd0, id_hold);
        if (pub_qos == 2'd1)
          emit(K_PUBACK, 8'd0, id_hold);
      end
    end
    ph = PH_HEADER;
  endtask

  task automatic deframe_byte(logic [7:0] b);
    int unsigned queued;
    int unsigned pos;
    int unsigned need;
    result_t     r;
    queued = due_results.size();
    case (ph)
      PH_LENGTH: begin
        rem_len = rem_len + (28'(b[6:0]) << (7 * len_idx));
        if (!b[7]) begin
          body_cnt  = '0;
          topic_len = '0;
          id_hold   = '0;
          dropping  = 1'b0;
          if (rem_len == 28'd0)
            close_packet();
          else
            ph = PH_BODY;
        end else if (len_idx + 1 >= MAX_LENGTH_BYTES) begin
          emit(K_LEN_ERR, 8'd0, 16'd0);
          ph = PH_HEADER;
        end else begin
          len_idx = len_idx + 2'd1;
        end
      end
      PH_BODY: begin
        pos = body_cnt;
        body_cnt = body_cnt + 28'd1;
        if (pkt_type == TYPE_CONNACK) begin
          if (pos == 1)
            id_hold = {8'd0, b};
        end else if (pkt_type == TYPE_PUBLISH) begin
          if (pos == 0) begin
            topic_len = {b, 8'h00};
          end else if (pos == 1) begin
            topic_len = topic_len | {8'd0, b};
            need = 2 + topic_len + ((pub_qos != 2'd0) ? 2 : 0);
            if (need > rem_len)
              dropping = 1'b1;
          end else if (!dropping) begin
            if (pos < 2 + topic_len)
              emit(K_TOPIC, b, 16'd0);
            else if (pub_qos != 2'd0 && pos < 4 + topic_len)
              id_hold = {id_hold[7:0], b};
            else
              emit(K_PAYLOAD, b, 16'd0);
          end
        end
        if (pos + 1 >= rem_len)
          close_packet();
      end
      default: begin
        pkt_type = b[7:4];
        pub_qos  = b[2:1];
        len_idx  = '0;
        rem_len  = '0;
        ph       = PH_LENGTH;
      end
    endcase
    if (due_results.size() > queued) begin
      r = due_results.pop_back();
      r.last = 1'b1;
      due_results.push_back(r);
    end
  endtask

  // Remaining length, optionally padded with redundant continuation words.
  task automatic push_length(int unsigned value, int unsigned pad);
    int unsigned rest;
    logic [7:0]  w;
    rest = value;
    do begin
      w = {1'b0, 7'(rest)};
      rest = rest >> 7;
      w[7] = (rest != 0) || (pad != 0);
      rx_stream.push_back(w);
    end while (rest != 0);
    while (pad != 0) begin
      pad = pad - 1;
      rx_stream.push_back((pad != 0) ? 8'h80 : 8'h00);
    end
  endtask

  task automatic add_packet();
    int unsigned pick;
    int unsigned rem;
    int unsigned tlen;
    int unsigned plen;
    int unsigned pad;
    logic [15:0] tl_field;
    logic [15:0] pid;
    logic [7:0]  hdr;
    logic [3:0]  flags;
    logic [3:0]  ty;
    logic [1:0]  qos;
    logic [7:0]  body[$];
    pick  = $urandom_range(0, 19);
    flags = 4'($urandom);
    pad   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (pick < 10) begin
      qos  = 2'($urandom);
      tlen = $urandom_range(0, 5);
      plen = $urandom_range(0, 8);
      pid  = 16'($urandom);
      rem  = 2 + tlen + ((qos != 2'd0) ? 2 : 0) + plen;
      tl_field = 16'(tlen);
      case ($urandom_range(0, 9))
        0: tl_field = ($urandom_range(0, 3) == 0) ? 16'hFFFF :
                      16'(tlen + plen + 1 + $urandom_range(0, 3));
        1: rem = $urandom_range(0, 1);
        default: ;
      endcase
      hdr = {TYPE_PUBLISH, flags[3], qos, flags[0]};
      body.push_back(tl_field[15:8]);
      body.push_back(tl_field[7:0]);
      repeat (tlen) body.push_back(8'($urandom));
      if (qos != 2'd0) begin
        body.push_back(pid[15:8]);
        body.push_back(pid[7:0]);
      end
    end else if (pick < 13) begin
      hdr = {TYPE_CONNACK, flags};
      case ($urandom_range(0, 5))
        0: rem = $urandom_range(0, 1);
        1: rem = $urandom_range(3, 5);
        default: rem = 2;
      endcase
      body.push_back(8'($urandom));
      body.push_back(($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom));
    end else if (pick < 15) begin
      hdr = {TYPE_SUBACK, flags};
      rem = $urandom_range(0, 4);
    end else if (pick < 17) begin
      do ty = 4'($urandom);
      while (ty == TYPE_CONNACK || ty == TYPE_PUBLISH || ty == TYPE_SUBACK);
      hdr = {ty, flags};
      rem = $urandom_range(0, 6);
    end else if (pick == 17) begin
      // Every length word keeps its continuation bit, so the length overflows.
      rx_stream.push_back(8'($urandom));
      repeat (MAX_LENGTH_BYTES) rx_stream.push_back(8'h80 | 8'($urandom));
      return;
    end else begin
      hdr = 8'($urandom);
      rem = $urandom_range(0, 15);
    end
    while (body.size() < rem) body.push_back(8'($urandom));
    rx_stream.push_back(hdr);
    push_length(rem, pad);
    for (int i = 0; i < rem; i++) rx_stream.push_back(body[i]);
  endtask

  // Input side: the next word is offered once the previous one has been taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (in_bus.valid && !in_acc) begin
    end else if (in_gap != 0) begin
      in_bus.valid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (rx_stream.size() != 0) begin
      if (in_count < idle_stop && hold_cnt == 0 && $urandom_range(0, 9) == 0) begin
        in_bus.valid <= 1'b0;
        in_gap <= $urandom_range(0, 14);
      end else begin
        in_bus.valid   <= 1'b1;
        in_bus.rx_byte <= rx_stream.pop_front();
      end
    end else begin
      in_bus.valid <= 1'b0;
    end
  end

  // Result side: random stalls, plus one long hold so that the block backs up.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_bus.ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && in_count >= HOLD_AT) begin
      out_bus.ready <= 1'b0;
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (out_gap != 0) begin
      out_bus.ready <= 1'b0;
      out_gap <= out_gap - 1;
    end else if (in_count < idle_stop && $urandom_range(0, 9) == 0) begin
      out_bus.ready <= 1'b0;
      out_gap <= $urandom_range(0, 14);
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    in_acc <= rst_n && in_bus.valid && in_bus.ready;
    if (rst_n && in_bus.valid && in_bus.ready) begin
      deframe_byte(in_bus.rx_byte);
      in_count <= in_count + 1;
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: result with none due: kind %0d data %02h id %04h last %0b", $time,
                 out_bus.kind, out_bus.data, out_bus.packet_id, out_bus.last);
        errors = errors + 1;
      end else begin
        want = due_results.pop_front();
        if (out_bus.kind !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, out_bus.kind);
          errors = errors + 1;
        end
        if (out_bus.data !== want.data) begin
          $display("%0t: data expected %02h actual %02h", $time, want.data, out_bus.data);
          errors = errors + 1;
        end
        if (out_bus.packet_id !== want.packet_id) begin
          $display("%0t: packet_id expected %04h actual %04h", $time, want.packet_id,
                   out_bus.packet_id);
          errors = errors + 1;
        end
        if (out_bus.last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_bus.last);
          errors = errors + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    in_bus.valid   = 1'b0;
    in_bus.rx_byte = 8'h00;
    out_bus.ready  = 1'b0;
    rx_stream = '{
      8'h20, 8'h02, 8'h00, 8'h00,                      // connack accepted
      8'h20, 8'h02, 8'h01, 8'h86,                      // connack rejected
      8'h2F, 8'h01, 8'h05,                             // connack body too short
      8'h90, 8'h00,                                    // suback with empty body
      8'h30, 8'h00,                                    // publish with empty body
      8'hFF, 8'h80, 8'h80, 8'h80, 8'h80,               // overlong length
      8'h32, 8'h06, 8'h00, 8'h01, 8'hFF, 8'h12, 8'h34, 8'hAB
    };
    while (rx_stream.size() < 28 + RANDOM_WORDS) add_packet();
    // A publish whose length never runs out: high length bits, QoS 2 id, open payload.
    rx_stream.push_back({TYPE_PUBLISH, 4'b0100});
    push_length(28'hFFF_FFFF, 0);
    rx_stream.push_back(8'h00);
    rx_stream.push_back(8'h02);
    repeat (4) rx_stream.push_back(8'($urandom));
    repeat (12) rx_stream.push_back(8'($urandom));
    total_words = rx_stream.size();
    idle_stop   = total_words - CALM_TAIL;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (in_count == total_words);
    wait (due_results.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/mqd_pkg.sv
hdl/mqd_in_if.sv
hdl/mqd_out_if.sv
hdl/mqd_core.sv
hdl/mqtt_receive_deframer_top.sv
dv/mqtt_receive_deframer_top_tb.sv
